// ===== hw/rtl/cdll_pkg.sv =====
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types and codes of the circular doubly linked list engine.
// ----------------------------------------------------------------------------
package cdll_pkg;

    localparam int POOL_NODES_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [3:0] REQ_INS_HEAD = 4'd0;
    localparam logic [3:0] REQ_INS_TAIL = 4'd1;
    localparam logic [3:0] REQ_INS_AT   = 4'd2;
    localparam logic [3:0] REQ_DEL_HEAD = 4'd3;
    localparam logic [3:0] REQ_DEL_TAIL = 4'd4;
    localparam logic [3:0] REQ_DEL_AT   = 4'd5;
    localparam logic [3:0] REQ_UPDATE   = 4'd6;
    localparam logic [3:0] REQ_SEARCH   = 4'd7;
    localparam logic [3:0] REQ_CLEAR    = 4'd8;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] data_value;
        logic signed [31:0] repl_value;
        logic signed [7:0]  position;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] list_length;
        logic [5:0] match_position;
    } t_rsp;

endpackage

// ===== hw/rtl/cdll_ram.sv =====
// ----------------------------------------------------------------------------
// cdll_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/circular_doubly_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_engine
// Circular doubly linked list in a node RAM {value, next, prev} with a
// free-slot stack RAM. One item at a time; the list walk reads one node/cycle.
// Error, clear and unknown items finish in idle; inserts and deletes walk to the
// position and relink its neighbours; update/search walk the list to a match.
// Result strobes in the cycle after the item finishes; busy low accepts next item.
// Search and update walk the whole list when the value is not found.
// Sync reset empties the list; no RAM clearing pass (fresh-slot watermark).
// ----------------------------------------------------------------------------
module circular_doubly_linked_list_engine
    import cdll_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_result
);

    localparam int AW = $clog2(POOL_NODES);
    localparam int VB = VALUE_BITS;
    localparam int EW = VB + 2 * AW;
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam logic [AW:0] POOL_CNT = (AW + 1)'(POOL_NODES);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_FIND   = 8'b0000_1000,
        S_FX1_RD = 8'b0001_0000,
        S_FX1_WR = 8'b0010_0000,
        S_FX2_RD = 8'b0100_0000,
        S_FX2_WR = 8'b1000_0000
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [EW-1:0] e);
        return e[2*AW-1:AW];
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [EW-1:0] e);
        return e[AW-1:0];
    endfunction

    function automatic logic [VB-1:0] f_val(input logic [EW-1:0] e);
        return e[EW-1:2*AW];
    endfunction

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [AW-1:0] r_head, n_head;
    logic [AW:0]   r_count, n_count;
    logic [AW:0]   r_ftop, n_ftop;
    logic [AW:0]   r_fmin, n_fmin;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_tgt, n_tgt;
    logic [AW-1:0] r_new, n_new;
    logic [AW-1:0] r_x1, n_x1;
    logic [AW-1:0] r_v1, n_v1;
    logic [AW-1:0] r_x2, n_x2;
    logic [AW-1:0] r_v2, n_v2;
    logic          r_strobe, n_strobe;
    t_rsp          r_rsp, n_rsp;

    logic          nd_we;
    logic [AW-1:0] nd_waddr, nd_raddr;
    logic [EW-1:0] nd_wdata, nd_rdata;
    logic          fs_we;
    logic [AW-1:0] fs_waddr, fs_raddr;
    logic [AW-1:0] fs_wdata, fs_rdata;

    logic          w_full;
    logic [CW-1:0] w_in_pos, w_in_cnt;
    logic [AW-1:0] w_pos;
    logic [AW-1:0] w_ftop_m1;
    logic [AW-1:0] w_slot;
    logic [VB-1:0] w_dv, w_nv;
    logic          w_ins, w_new_head;
    logic          fin;
    logic [2:0]    fin_status;
    logic [AW-1:0] fin_match;

    cdll_ram #(.WIDTH(EW), .DEPTH(POOL_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    cdll_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign w_full     = (r_ftop == '0) || (r_count >= POOL_CNT);
    assign w_in_pos   = CW'(i_req.position[6:0]);
    assign w_in_cnt   = CW'(r_count);
    assign w_pos      = AW'(r_req.position[6:0]);
    assign w_ftop_m1  = AW'(r_ftop - 1'b1);
    // entries below the low watermark were never written and hold their index
    assign w_slot     = ({1'b0, w_ftop_m1} < r_fmin) ? w_ftop_m1 : fs_rdata;
    assign w_dv       = VB'(r_req.data_value);
    assign w_nv       = VB'(r_req.repl_value);
    assign w_ins      = (r_req.req_type == REQ_INS_HEAD) || (r_req.req_type == REQ_INS_TAIL)
                     || (r_req.req_type == REQ_INS_AT);
    assign w_new_head = (r_req.req_type == REQ_INS_HEAD)
                     || ((r_req.req_type == REQ_INS_AT) && (w_pos == '0));

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_head     = r_head;
        n_count    = r_count;
        n_ftop     = r_ftop;
        n_fmin     = r_fmin;
        n_cur      = r_cur;
        n_idx      = r_idx;
        n_tgt      = r_tgt;
        n_new      = r_new;
        n_x1       = r_x1;
        n_v1       = r_v1;
        n_x2       = r_x2;
        n_v2       = r_v2;
        nd_we      = 1'b0;
        nd_waddr   = r_cur;
        nd_wdata   = nd_rdata;
        nd_raddr   = r_head;
        fs_we      = 1'b0;
        fs_waddr   = AW'(r_ftop);
        fs_wdata   = r_cur;
        fs_raddr   = w_ftop_m1;
        fin        = 1'b0;
        fin_status = ST_DONE;
        fin_match  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    case (i_req.req_type) inside
                        REQ_INS_HEAD, REQ_INS_TAIL: begin
                            if (w_full) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                        REQ_INS_AT: begin
                            if (i_req.position[7] || (w_in_pos > w_in_cnt)) begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end else if (w_full) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                        REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_UPDATE, REQ_SEARCH: begin
                            if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                        REQ_DEL_AT: begin
                            if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else if (i_req.position[7] || (w_in_pos >= w_in_cnt)) begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                        REQ_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                            n_ftop  = POOL_CNT;
                            n_fmin  = POOL_CNT;
                            fin     = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_SETUP: begin
                // node read data holds the head entry here
                n_idx   = '0;
                n_tgt   = '0;
                n_cur   = r_head;
                n_state = S_WALK;
                case (r_req.req_type) inside
                    REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
                        n_new  = w_slot;
                        n_ftop = r_ftop - 1'b1;
                        if ({1'b0, w_ftop_m1} < r_fmin) begin
                            n_fmin = {1'b0, w_ftop_m1};
                        end
                        if (r_count == '0) begin
                            nd_we    = 1'b1;
                            nd_waddr = w_slot;
                            nd_wdata = {w_dv, w_slot, w_slot};
                            n_head   = w_slot;
                            n_count  = r_count + 1'b1;
                            n_state  = S_IDLE;
                            fin      = 1'b1;
                        end else if ((r_req.req_type == REQ_INS_AT) && (w_pos != '0)) begin
                            n_tgt = w_pos - 1'b1;
                        end else begin
                            nd_raddr = f_prev(nd_rdata);
                            n_cur    = f_prev(nd_rdata);
                        end
                    end
                    REQ_DEL_TAIL: begin
                        nd_raddr = f_prev(nd_rdata);
                        n_cur    = f_prev(nd_rdata);
                    end
                    REQ_DEL_AT: begin
                        n_tgt = w_pos;
                    end
                    REQ_UPDATE, REQ_SEARCH: begin
                        n_state = S_FIND;
                    end
                    default: begin
                    end
                endcase
            end

            S_WALK: begin
                if (r_idx == r_tgt) begin
                    if (w_ins) begin
                        nd_we    = 1'b1;
                        nd_waddr = r_new;
                        nd_wdata = {w_dv, f_next(nd_rdata), r_cur};
                        n_x1     = r_cur;
                        n_v1     = r_new;
                        n_x2     = f_next(nd_rdata);
                        n_v2     = r_new;
                        n_count  = r_count + 1'b1;
                        if (w_new_head) begin
                            n_head = r_new;
                        end
                        n_state  = S_FX1_RD;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (r_ftop < POOL_CNT) begin
                            fs_we  = 1'b1;
                            n_ftop = r_ftop + 1'b1;
                        end
                        if (r_count == (AW + 1)'(1)) begin
                            n_head  = '0;
                            n_state = S_IDLE;
                            fin     = 1'b1;
                        end else begin
                            if (r_cur == r_head) begin
                                n_head = f_next(nd_rdata);
                            end
                            n_x1    = f_prev(nd_rdata);
                            n_v1    = f_next(nd_rdata);
                            n_x2    = f_next(nd_rdata);
                            n_v2    = f_prev(nd_rdata);
                            n_state = S_FX1_RD;
                        end
                    end
                end else begin
                    nd_raddr = f_next(nd_rdata);
                    n_cur    = f_next(nd_rdata);
                    n_idx    = r_idx + 1'b1;
                end
            end

            S_FIND: begin
                if (f_val(nd_rdata) == w_dv) begin
                    if (r_req.req_type == REQ_UPDATE) begin
                        nd_we    = 1'b1;
                        nd_wdata = {w_nv, f_next(nd_rdata), f_prev(nd_rdata)};
                    end
                    fin_match = r_idx;
                    fin       = 1'b1;
                    n_state   = S_IDLE;
                end else if ({1'b0, r_idx} == r_count - 1'b1) begin
                    fin_status = ST_NOT_FOUND;
                    fin        = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    nd_raddr = f_next(nd_rdata);
                    n_cur    = f_next(nd_rdata);
                    n_idx    = r_idx + 1'b1;
                end
            end

            S_FX1_RD: begin
                nd_raddr = r_x1;
                n_state  = S_FX1_WR;
            end

            S_FX1_WR: begin
                nd_we    = 1'b1;
                nd_waddr = r_x1;
                nd_wdata = {f_val(nd_rdata), r_v1, f_prev(nd_rdata)};
                n_state  = S_FX2_RD;
            end

            S_FX2_RD: begin
                nd_raddr = r_x2;
                n_state  = S_FX2_WR;
            end

            S_FX2_WR: begin
                nd_we    = 1'b1;
                nd_waddr = r_x2;
                nd_wdata = {f_val(nd_rdata), f_next(nd_rdata), r_v2};
                fin      = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_strobe                = fin;
        n_rsp.status            = fin_status;
        n_rsp.list_length       = 7'(n_count);
        n_rsp.match_position    = 6'(fin_match);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_ftop   <= POOL_CNT;
            r_fmin   <= POOL_CNT;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ftop   <= n_ftop;
            r_fmin   <= n_fmin;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_cur <= n_cur;
        r_idx <= n_idx;
        r_tgt <= n_tgt;
        r_new <= n_new;
        r_x1  <= n_x1;
        r_v1  <= n_v1;
        r_x2  <= n_x2;
        r_v2  <= n_v2;
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_rsp;

endmodule

// ===== hw/rtl/cdll_checker.sv =====
// ----------------------------------------------------------------------------
// cdll_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module cdll_checker
    import cdll_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_req i_req,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_result
);

    // an accepted item either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted item neither busy nor answered");

    // results are only posted as the sequencer returns to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status <= ST_NOT_FOUND))
        else $error("illegal status code");

    a_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_DONE)) |-> (o_result.match_position == '0))
        else $error("match position set on failed item");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_EMPTY)) |-> (o_result.list_length == '0))
        else $error("empty status with nonzero length");

endmodule

bind circular_doubly_linked_list_engine cdll_checker u_cdll_checker (.*);
